FILE: rtl/core/lcr_pkg.sv
// Shared types and constants for the longest consecutive run block.
package lcr_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RUN_W    = 5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAIR  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_element;
  } lcr_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RUN_W-1:0]    run_length;
  } lcr_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_prev;
    logic shift;
    logic place;
    logic scan_init;
    logic scan_first;
    logic scan_step;
    logic emit;
  } lcr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic greater;
    logic last;
    logic few;
    logic scan_end;
    logic overflow;
  } lcr_stat_t;

endpackage

FILE: rtl/core/longest_consecutive_run_length.sv
// Top level: longest run of consecutive integers over a set of words.
//
// Input: a word (signed value, last_element flag) is taken on a rising
// edge with start high and busy low, and is inserted into an ascending
// store held in a RAM by walking down from the top, reading the element
// below and moving it up while it is greater than the new word; a set's
// first word lands at the bottom directly, and a word is dropped when
// the store is full.
// After the word marked last is stored or dropped, the store is scanned
// once, one RAM read per element; the scan is skipped when the set
// overflowed or holds fewer than two elements. Then the result is shown.
// Output: result_valid_o is high for exactly one cycle with status and
// run_length on result_o; the receiver has no way to stall it, so it must
// take the word in that cycle. Status: ok, too many elements, no pair.
// After the result the set is empty and busy falls.
// Reset clears the element count, the overflow flag and the controller;
// store contents are not cleared, only written entries are ever read.
module longest_consecutive_run_length #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lcr_pkg::lcr_in_t  in_i,
  output logic              result_valid_o,
  output lcr_pkg::lcr_out_t result_o
);

  import lcr_pkg::*;

  lcr_cmd_t  cmd;
  lcr_stat_t stat;

  lcr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  lcr_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

  // result is only shown while the block is working on a set
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle");

  a_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status != ST_OK) |-> (result_o.run_length == '0))
    else $error("non-zero run length with failing status");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

endmodule

FILE: rtl/core/lcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/lcr_datapath.sv
// Datapath: sorted store, insertion pointer, counters and run scan.
module lcr_datapath #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcr_pkg::lcr_in_t  in_i,
  input  lcr_pkg::lcr_cmd_t cmd_i,
  output lcr_pkg::lcr_stat_t stat_o,
  output lcr_pkg::lcr_out_t  result_o
);

  import lcr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      overflow_q, overflow_d;
  logic signed [VALUE_W-1:0] v_q;
  logic                      last_q;
  logic [CNT_W-1:0]          pos_q;
  logic [CNT_W-1:0]          idx_q;
  logic [CNT_W-1:0]          cur_q;
  logic [CNT_W-1:0]          best_q;
  logic signed [VALUE_W-1:0] prev_q;

  logic                      we;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [VALUE_W-1:0]        wdata, rdata;
  logic [CNT_W-1:0]          pos_m1, idx_p1, cnt_m1, cur_inc;
  logic signed [VALUE_W:0]   diff;
  logic                      pair;

  assign pos_m1  = pos_q - CNT_W'(1);
  assign idx_p1  = idx_q + CNT_W'(1);
  assign cnt_m1  = count_q - CNT_W'(1);
  assign cur_inc = cur_q + CNT_W'(1);

  // step of one tested on 33 bits so the extremes do not wrap
  assign diff = {rdata[VALUE_W-1], rdata} - {prev_q[VALUE_W-1], prev_q};
  assign pair = (diff == (VALUE_W+1)'(1));

  always_comb begin
    we    = 1'b0;
    waddr = pos_q[ADDR_W-1:0];
    wdata = v_q;
    raddr = '0;
    if (cmd_i.shift) begin
      we    = 1'b1;
      wdata = rdata;
    end
    if (cmd_i.place) begin
      we = 1'b1;
    end
    if (cmd_i.rd_prev) begin
      raddr = pos_m1[ADDR_W-1:0];
    end
    if (cmd_i.scan_first) begin
      raddr = idx_q[ADDR_W-1:0];
    end
    if (cmd_i.scan_step) begin
      raddr = idx_p1[ADDR_W-1:0];
    end
  end

  lcr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (cmd_i.accept && (count_q == CNT_W'(MAX_ELEMENTS))) begin
      overflow_d = 1'b1;
    end
    if (cmd_i.place) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q    <= in_i.value;
      last_q <= in_i.last_element;
      pos_q  <= count_q;
    end
    if (cmd_i.shift) begin
      pos_q <= pos_m1;
    end
    if (cmd_i.scan_init) begin
      idx_q  <= CNT_W'(1);
      cur_q  <= CNT_W'(1);
      best_q <= '0;
    end
    if (cmd_i.scan_first) begin
      prev_q <= rdata;
    end
    if (cmd_i.scan_step) begin
      prev_q <= rdata;
      idx_q  <= idx_p1;
      if (pair) begin
        cur_q <= cur_inc;
        if (cur_inc > best_q) begin
          best_q <= cur_inc;
        end
      end else begin
        cur_q <= CNT_W'(1);
      end
    end
  end

  assign stat_o.full     = (count_q == CNT_W'(MAX_ELEMENTS));
  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.greater  = ($signed(rdata) > v_q);
  assign stat_o.last     = last_q;
  assign stat_o.few      = (count_q < CNT_W'(2));
  assign stat_o.scan_end = (idx_q == cnt_m1);
  assign stat_o.overflow = overflow_q;

  always_comb begin
    if (overflow_q) begin
      result_o.status     = ST_TOO_MANY;
      result_o.run_length = '0;
    end else if (best_q == '0) begin
      result_o.status     = ST_NO_PAIR;
      result_o.run_length = '0;
    end else begin
      result_o.status     = ST_OK;
      result_o.run_length = RUN_W'(best_q);
    end
  end

endmodule

FILE: rtl/core/lcr_ctrl.sv
// Controller: sequences insertion, run scan and result strobe.
module lcr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lcr_pkg::lcr_stat_t stat_i,
  output lcr_pkg::lcr_cmd_t  cmd_o,
  output logic               result_valid_o
);

  import lcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SCAN,
    S_SFIRST,
    S_STEP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.full) begin
          state_d = stat_i.last ? S_SCAN : S_IDLE;
        end else if (stat_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = stat_i.last ? S_SCAN : S_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = S_READ;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = stat_i.last ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_init = 1'b1;
        state_d = (stat_i.overflow || stat_i.few) ? S_EMIT : S_SFIRST;
      end
      S_SFIRST: begin
        cmd_o.scan_first = 1'b1;
        state_d          = S_STEP;
      end
      S_STEP: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_EMIT);

endmodule
